FILE: hw/rtl/ybd_pkg.sv
// ybd_pkg: shared types, widths, register codes and lookup tables of the yolo box decoder
// no dependencies; used by the stream interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package ybd_pkg;

    localparam int ANCHOR_COUNT = 3;
    localparam int ANCHOR_SLOTS = 3;

    localparam int LOGIT_W     = 16;
    localparam int CHANNEL_W   = 8;
    localparam int GRID_W      = 8;
    localparam int SEL_W       = 2;
    localparam int DECODED_W   = 32;
    localparam int STRIDE_BITS = 8;
    localparam int ANCHOR_BITS = 10;
    localparam int WDATA_W     = 10;
    localparam int INDEX_W     = 3;

    localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 8'd32;

    // log2(e) in q1.16
    localparam logic signed [33:0] LOG2E_Q16 = 34'sd94548;

    localparam logic [CHANNEL_W-1:0] CH_X = 8'd0;
    localparam logic [CHANNEL_W-1:0] CH_Y = 8'd1;
    localparam logic [CHANNEL_W-1:0] CH_W = 8'd2;
    localparam logic [CHANNEL_W-1:0] CH_H = 8'd3;

    typedef enum logic [INDEX_W-1:0] {
        REG_STRIDE_X  = 3'd0,
        REG_STRIDE_Y  = 3'd1,
        REG_ANC_WID0  = 3'd2,
        REG_ANC_WID1  = 3'd3,
        REG_ANC_WID2  = 3'd4,
        REG_ANC_HGT0  = 3'd5,
        REG_ANC_HGT1  = 3'd6,
        REG_ANC_HGT2  = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_X,
        KIND_Y,
        KIND_EXP,
        KIND_SIG
    } kind_t;

    // sigmoid(k/2), k = 0..16, q0.16
    localparam logic [15:0] SIG_TAB [17] = '{
        16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
        16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
        16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
    };

    // 2^(k/16), k = 0..16, q2.16
    localparam logic [17:0] POW2_TAB [17] = '{
        18'd65536,  18'd68438,  18'd71468,  18'd74632,  18'd77936,  18'd81386,
        18'd84990,  18'd88752,  18'd92682,  18'd96785,  18'd101070, 18'd105545,
        18'd110218, 18'd115098, 18'd120193, 18'd125515, 18'd131072
    };

endpackage

`default_nettype wire

FILE: hw/rtl/ybd_if.sv
// ybd_in_if and ybd_out_if: valid/ready request channels of the yolo box decoder
// depends on ybd_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ybd_in_if
    import ybd_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [LOGIT_W-1:0]   logit;
    logic [CHANNEL_W-1:0]        channel;
    logic [GRID_W-1:0]           grid_col;
    logic [GRID_W-1:0]           grid_row;
    logic [SEL_W-1:0]            anchor_sel;

    modport source (output valid, logit, channel, grid_col, grid_row, anchor_sel,
                    input ready);
    modport sink   (input valid, logit, channel, grid_col, grid_row, anchor_sel,
                    output ready);
endinterface

interface ybd_out_if
    import ybd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [DECODED_W-1:0]  decoded;
    logic                  saturated;

    modport source (output valid, decoded, saturated, input ready);
    modport sink   (input valid, decoded, saturated, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/yolo_box_decode_top.sv
// yolo_box_decode_top: four-stage pipelined decoder of detector logits into box values
// depends on ybd_pkg and the ybd_in_if / ybd_out_if interfaces
//
//   port     | role              | payload
//   ---------+-------------------+----------------------------------------------
//   item     | request in        | logit, channel, grid_col, grid_row, anchor_sel
//   result   | request out       | decoded, saturated
//   wr_*     | register write    | wr_index, wr_data
//
// one request per cycle sustained while result.ready holds; a request passes stages 1 to 4 in order before result.valid
// stages: sigmoid lookup and log2(e) multiply, interpolation, scale multiply, shift and round
// each stage holds when the next is full and stalled; a stage empties as it hands on
// reset clears valid bits and restores the register defaults (strides 32, anchors 0)
`timescale 1ns / 1ps
`default_nettype none

module yolo_box_decode_top
    import ybd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    ybd_in_if.sink                    item,
    ybd_out_if.source                 result,
    input  wire logic                 wr_en,
    input  wire logic [INDEX_W-1:0]   wr_index,
    input  wire logic [WDATA_W-1:0]   wr_data
);

    // configuration registers
    logic [STRIDE_BITS-1:0] stride_x_reg;
    logic [STRIDE_BITS-1:0] stride_y_reg;
    logic [ANCHOR_BITS-1:0] anc_wid_reg [ANCHOR_SLOTS];
    logic [ANCHOR_BITS-1:0] anc_hgt_reg [ANCHOR_SLOTS];

    // handshake
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // stage 1
    kind_t                  s1_kind_reg;
    logic                   s1_neg_reg;
    logic [15:0]            s1_sbase_reg;
    logic [12:0]            s1_sdiff_reg;
    logic [6:0]             s1_sf_reg;
    logic signed [8:0]      s1_n_reg;
    logic [3:0]             s1_ei_reg;
    logic [11:0]            s1_ef_reg;
    logic [GRID_W-1:0]      s1_cell_reg;
    logic [STRIDE_BITS-1:0] s1_stride_reg;
    logic [ANCHOR_BITS-1:0] s1_anchor_reg;

    // stage 2
    kind_t                  s2_kind_reg;
    logic [15:0]            s2_sig_reg;
    logic [17:0]            s2_m_reg;
    logic signed [8:0]      s2_n_reg;
    logic [GRID_W-1:0]      s2_cell_reg;
    logic [STRIDE_BITS-1:0] s2_stride_reg;
    logic [ANCHOR_BITS-1:0] s2_anchor_reg;

    // stage 3
    kind_t               s3_kind_reg;
    logic [15:0]         s3_sig_reg;
    logic [31:0]         s3_prod_reg;
    logic [27:0]         s3_q_reg;
    logic signed [9:0]   s3_sh_reg;

    // stage 4
    logic [DECODED_W-1:0] dec_reg;
    logic                 sat_reg;

    // stage 1 combinational values
    kind_t                  kind_next;
    logic                   neg_next;
    logic [15:0]            sbase_next;
    logic [12:0]            sdiff_next;
    logic [6:0]             sf_next;
    logic signed [8:0]      n_next;
    logic [3:0]             ei_next;
    logic [11:0]            ef_next;
    logic [GRID_W-1:0]      cell_next;
    logic [STRIDE_BITS-1:0] stride_next;
    logic [ANCHOR_BITS-1:0] anchor_next;

    // later stage combinational values
    logic [15:0]          sig_next;
    logic [17:0]          m_next;
    logic [31:0]          prod_next;
    logic [27:0]          q_next;
    logic signed [9:0]    sh_next;
    logic [DECODED_W-1:0] dec_next;
    logic                 sat_next;

    assign en4 = !v4_reg || result.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign item.ready       = en1;
    assign result.valid     = v4_reg;
    assign result.decoded   = dec_reg;
    assign result.saturated = sat_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_x_reg <= STRIDE_RESET;
            stride_y_reg <= STRIDE_RESET;
            for (int k = 0; k < ANCHOR_SLOTS; k++)
            begin
                anc_wid_reg[k] <= '0;
                anc_hgt_reg[k] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_STRIDE_X: stride_x_reg   <= wr_data[STRIDE_BITS-1:0];
                REG_STRIDE_Y: stride_y_reg   <= wr_data[STRIDE_BITS-1:0];
                REG_ANC_WID0: anc_wid_reg[0] <= wr_data;
                REG_ANC_WID1: anc_wid_reg[1] <= wr_data;
                REG_ANC_WID2: anc_wid_reg[2] <= wr_data;
                REG_ANC_HGT0: anc_hgt_reg[0] <= wr_data;
                REG_ANC_HGT1: anc_hgt_reg[1] <= wr_data;
                REG_ANC_HGT2: anc_hgt_reg[2] <= wr_data;
                default:      stride_x_reg   <= stride_x_reg;
            endcase
        end
    end

    // stage 1: decode, |logit| table lookup, log2(e) multiply
    always_comb
    begin
        logic [16:0]        x_ext;
        logic [16:0]        a;
        logic               big;
        logic [3:0]         si;
        logic signed [33:0] p;

        x_ext = {item.logit[LOGIT_W-1], item.logit};
        a     = item.logit[LOGIT_W-1] ? (~x_ext + 17'd1) : x_ext;
        big   = |a[16:11];
        si    = a[10:7];

        neg_next = item.logit[LOGIT_W-1];
        if (big)
        begin
            sbase_next = SIG_TAB[16];
            sdiff_next = '0;
            sf_next    = '0;
        end
        else
        begin
            sbase_next = SIG_TAB[5'(si)];
            sdiff_next = 13'(SIG_TAB[5'(si) + 5'd1] - SIG_TAB[5'(si)]);
            sf_next    = a[6:0];
        end

        p       = 34'(item.logit) * LOG2E_Q16;
        n_next  = p[32:24];
        ei_next = p[23:20];
        ef_next = p[19:8];

        unique case (item.channel) inside
            CH_X:       kind_next = KIND_X;
            CH_Y:       kind_next = KIND_Y;
            CH_W, CH_H: kind_next = KIND_EXP;
            default:    kind_next = KIND_SIG;
        endcase

        cell_next   = (kind_next == KIND_X) ? item.grid_col : item.grid_row;
        stride_next = (kind_next == KIND_X) ? stride_x_reg : stride_y_reg;

        if (32'(item.anchor_sel) < ANCHOR_COUNT)
            anchor_next = (item.channel == CH_W) ? anc_wid_reg[item.anchor_sel]
                                                 : anc_hgt_reg[item.anchor_sel];
        else
            anchor_next = '0;
    end

    // stage 2: linear interpolation of both tables
    always_comb
    begin
        logic [19:0] sprod;
        logic [15:0] s;
        logic [16:0] sneg;
        logic [12:0] ediff;
        logic [24:0] eprod;

        sprod    = 20'(s1_sdiff_reg) * 20'(s1_sf_reg);
        s        = s1_sbase_reg + 16'((21'(sprod) + 21'd64) >> 7);
        sneg     = 17'h10000 - 17'(s);
        sig_next = s1_neg_reg ? sneg[15:0] : s;

        ediff  = 13'(POW2_TAB[5'(s1_ei_reg) + 5'd1] - POW2_TAB[5'(s1_ei_reg)]);
        eprod  = 25'(ediff) * 25'(s1_ef_reg);
        m_next = POW2_TAB[5'(s1_ei_reg)] + 18'((26'(eprod) + 26'd2048) >> 12);
    end

    // stage 3: scale by stride or anchor
    always_comb
    begin
        prod_next = 32'({s2_cell_reg, s2_sig_reg}) * 32'(s2_stride_reg);
        q_next    = 28'(s2_m_reg) * 28'(s2_anchor_reg);
        sh_next   = 10'(s2_n_reg) - 10'sd4;
    end

    // stage 4: round, shift and saturate
    always_comb
    begin
        logic [59:0] wide;
        logic [9:0]  r;
        logic [27:0] t;

        wide     = '0;
        r        = '0;
        t        = '0;
        dec_next = '0;
        sat_next = 1'b0;

        case (s3_kind_reg)
            KIND_X, KIND_Y:
                dec_next = 32'((33'(s3_prod_reg) + 33'd8) >> 4);
            KIND_SIG:
                dec_next = 32'((17'(s3_sig_reg) + 17'd8) >> 4);
            default:
            begin
                if (s3_q_reg == '0)
                    dec_next = '0;
                else if (s3_sh_reg >= 0)
                begin
                    wide = 60'(s3_q_reg) << s3_sh_reg[4:0];
                    if ((s3_sh_reg >= 10'sd32) || (|wide[59:32]))
                    begin
                        dec_next = '1;
                        sat_next = 1'b1;
                    end
                    else
                        dec_next = wide[31:0];
                end
                else
                begin
                    r = 10'(-s3_sh_reg);
                    if (r >= 10'd40)
                        dec_next = '0;
                    else
                    begin
                        t        = s3_q_reg >> 6'(r - 10'd1);
                        dec_next = 32'((29'(t) + 29'd1) >> 1);
                    end
                end
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= item.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_kind_reg   <= kind_next;
            s1_neg_reg    <= neg_next;
            s1_sbase_reg  <= sbase_next;
            s1_sdiff_reg  <= sdiff_next;
            s1_sf_reg     <= sf_next;
            s1_n_reg      <= n_next;
            s1_ei_reg     <= ei_next;
            s1_ef_reg     <= ef_next;
            s1_cell_reg   <= cell_next;
            s1_stride_reg <= stride_next;
            s1_anchor_reg <= anchor_next;
        end
        if (en2)
        begin
            s2_kind_reg   <= s1_kind_reg;
            s2_sig_reg    <= sig_next;
            s2_m_reg      <= m_next;
            s2_n_reg      <= s1_n_reg;
            s2_cell_reg   <= s1_cell_reg;
            s2_stride_reg <= s1_stride_reg;
            s2_anchor_reg <= s1_anchor_reg;
        end
        if (en3)
        begin
            s3_kind_reg <= s2_kind_reg;
            s3_sig_reg  <= s2_sig_reg;
            s3_prod_reg <= prod_next;
            s3_q_reg    <= q_next;
            s3_sh_reg   <= sh_next;
        end
        if (en4)
        begin
            dec_reg <= dec_next;
            sat_reg <= sat_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// testbench: self-checking bench of yolo_box_decode_top, one request in and one result out
// depends on ybd_pkg, the ybd_in_if / ybd_out_if interfaces and the top level
// predicts every decoded value bit for bit and checks it with random idling on both sides
`timescale 1ns / 1ps

module testbench;
    import ybd_pkg::*;

    localparam int     PIPE_DEPTH = 4;
    localparam longint LOG2E_FIX  = 94548;
    localparam int     LIMIT_NS   = 2_000_000;
    localparam int     RAND_PHASES = 8;
    localparam int     PHASE_REQS  = 125;

    localparam logic [CHANNEL_W-1:0] CH_CONF = 8'd4;
    localparam logic [CHANNEL_W-1:0] CH_LAST = 8'd255;

    typedef struct packed {
        logic signed [LOGIT_W-1:0] logit;
        logic [CHANNEL_W-1:0]      channel;
        logic [GRID_W-1:0]         grid_col;
        logic [GRID_W-1:0]         grid_row;
        logic [SEL_W-1:0]          anchor_sel;
    } logit_req_t;

    typedef struct packed {
        logic [DECODED_W-1:0] decoded;
        logic                 saturated;
    } box_res_t;

    // sigmoid(k/2) in q0.16 and 2^(k/16) in q2.16
    int unsigned sigmoid_lut[17] = '{
        32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
        64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
    };
    int unsigned pow2_lut[17] = '{
        65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
        96785, 101070, 105545, 110218, 115098, 120193, 125515, 131072
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [INDEX_W-1:0] wr_index = '0;
    logic [WDATA_W-1:0] wr_data = '0;

    // register copy used for prediction
    logic [STRIDE_BITS-1:0] stride_x = 8'd32;
    logic [STRIDE_BITS-1:0] stride_y = 8'd32;
    logic [ANCHOR_BITS-1:0] anc_wid [ANCHOR_SLOTS] = '{default: '0};
    logic [ANCHOR_BITS-1:0] anc_hgt [ANCHOR_SLOTS] = '{default: '0};

    logit_req_t pending_q [$];
    box_res_t   decoded_q [$];

    bit item_fired = 1'b0;
    bit res_fired  = 1'b0;
    bit in_burst   = 1'b0;
    bit out_burst  = 1'b0;
    int item_wait  = 0;
    int out_wait   = 0;

    int errors       = 0;
    int reqs_taken   = 0;
    int results_seen = 0;
    int sat_seen     = 0;
    int settings_run = 1;

    ybd_in_if  req_if ();
    ybd_out_if res_if ();

    yolo_box_decode_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (req_if),
        .result   (res_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #LIMIT_NS;
        $display("timeout with %0d results still expected", decoded_q.size());
        $display("testbench: FAIL");
        $finish;
    end

    function automatic int unsigned sigmoid_q16(logic signed [LOGIT_W-1:0] lg);
        int          x;
        int unsigned a;
        int unsigned idx;
        int unsigned frac;
        int unsigned s;
        x = int'(lg);
        a = (x < 0) ? -x : x;
        idx = a >> 7;
        frac = a & 127;
        if (idx >= 16)
            s = sigmoid_lut[16];
        else
            s = sigmoid_lut[idx]
                + (((sigmoid_lut[idx+1] - sigmoid_lut[idx]) * frac + 64) >> 7);
        return (x < 0) ? 65536 - s : s;
    endfunction

    function automatic box_res_t exp_scale(logic signed [LOGIT_W-1:0] lg, int unsigned anc);
        box_res_t    r;
        longint      p;
        longint      u;
        longint      m;
        longint      q;
        longint      v;
        int          n;
        int          sh;
        int unsigned g;
        int unsigned idx;
        int unsigned frac;
        r = '0;
        p = longint'(lg) * LOG2E_FIX;
        u = (p + (longint'(1) << 32)) >>> 8;
        n = int'(u >> 16) - 256;
        g = 32'(u & 64'hFFFF);
        idx = g >> 12;
        frac = g & 4095;
        m = longint'(pow2_lut[idx]
                     + (((pow2_lut[idx+1] - pow2_lut[idx]) * frac + 2048) >> 12));
        q = m * longint'(anc);
        sh = n - 4;
        if (q == 0)
            r.decoded = '0;
        else if (sh >= 32)
            r = '{decoded: '1, saturated: 1'b1};
        else if (sh >= 0)
        begin
            v = q << sh;
            if (v > 64'hFFFF_FFFF)
                r = '{decoded: '1, saturated: 1'b1};
            else
                r.decoded = 32'(v);
        end
        else if (-sh >= 40)
            r.decoded = '0;
        else
            r.decoded = 32'((q + (longint'(1) << (-sh - 1))) >> (-sh));
        return r;
    endfunction

    function automatic box_res_t decode_logit(logit_req_t rq);
        box_res_t    r;
        longint      v;
        int unsigned anc;
        r = '0;
        anc = 0;
        if (rq.channel == CH_X || rq.channel == CH_Y)
        begin
            if (rq.channel == CH_X)
                v = (longint'(sigmoid_q16(rq.logit)) + (longint'(rq.grid_col) << 16))
                    * longint'(stride_x);
            else
                v = (longint'(sigmoid_q16(rq.logit)) + (longint'(rq.grid_row) << 16))
                    * longint'(stride_y);
            r.decoded = 32'((v + 8) >> 4);
        end
        else if (rq.channel == CH_W || rq.channel == CH_H)
        begin
            if (rq.anchor_sel < ANCHOR_COUNT)
                anc = (rq.channel == CH_W) ? 32'(anc_wid[rq.anchor_sel])
                                           : 32'(anc_hgt[rq.anchor_sel]);
            r = exp_scale(rq.logit, anc);
        end
        else
            r.decoded = 32'((sigmoid_q16(rq.logit) + 8) >> 4);
        return r;
    endfunction

    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 49) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 5);
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic push_req(input logic signed [LOGIT_W-1:0] lg, input logic [CHANNEL_W-1:0] ch,
                            input logic [GRID_W-1:0] col, input logic [GRID_W-1:0] row,
                            input logic [SEL_W-1:0] sel);
        logit_req_t rq;
        rq = '{logit: lg, channel: ch, grid_col: col, grid_row: row, anchor_sel: sel};
        pending_q.push_back(rq);
    endtask

    task automatic push_random_req();
        logit_req_t rq;
        if ($urandom_range(0, 2) == 0)
            rq.logit = 16'($urandom);
        else
            rq.logit = 16'($urandom_range(0, 5120) - 2560);
        if ($urandom_range(0, 9) < 8)
            rq.channel = 8'($urandom_range(0, 4));
        else
            rq.channel = 8'($urandom);
        rq.grid_col = 8'($urandom);
        rq.grid_row = 8'($urandom);
        rq.anchor_sel = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        pending_q.push_back(rq);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [WDATA_W-1:0] val);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        case (idx)
            REG_STRIDE_X: stride_x = val[STRIDE_BITS-1:0];
            REG_STRIDE_Y: stride_y = val[STRIDE_BITS-1:0];
            REG_ANC_WID0: anc_wid[0] = val;
            REG_ANC_WID1: anc_wid[1] = val;
            REG_ANC_WID2: anc_wid[2] = val;
            REG_ANC_HGT0: anc_hgt[0] = val;
            REG_ANC_HGT1: anc_hgt[1] = val;
            REG_ANC_HGT2: anc_hgt[2] = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [WDATA_W-1:0] sx, input logic [WDATA_W-1:0] sy,
                                 input logic [WDATA_W-1:0] w0, input logic [WDATA_W-1:0] w1,
                                 input logic [WDATA_W-1:0] w2, input logic [WDATA_W-1:0] h0,
                                 input logic [WDATA_W-1:0] h1, input logic [WDATA_W-1:0] h2);
        write_reg(REG_STRIDE_X, sx);
        write_reg(REG_STRIDE_Y, sy);
        write_reg(REG_ANC_WID0, w0);
        write_reg(REG_ANC_WID1, w1);
        write_reg(REG_ANC_WID2, w2);
        write_reg(REG_ANC_HGT0, h0);
        write_reg(REG_ANC_HGT1, h1);
        write_reg(REG_ANC_HGT2, h2);
        @(negedge clk);
        wr_en <= 1'b0;
        settings_run++;
    endtask

    function automatic logic [WDATA_W-1:0] pick_stride();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 10'd1;
            2:       return 10'h3FF;
            3:       return 10'($urandom);
            default: return 10'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [WDATA_W-1:0] pick_anchor();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 10'd1;
            2:       return 10'd1023;
            default: return 10'($urandom);
        endcase
    endfunction

    // block until every request is taken and every result has come back
    task automatic drain();
        while (pending_q.size() != 0 || req_if.valid || decoded_q.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (item_fired || !req_if.valid))
        begin
            if (item_fired)
                item_wait = draw_wait(in_burst);
            if (item_wait > 0 || pending_q.size() == 0)
            begin
                req_if.valid <= 1'b0;
                if (item_wait > 0)
                    item_wait--;
            end
            else
            begin
                logit_req_t rq;
                rq = pending_q.pop_front();
                req_if.valid <= 1'b1;
                req_if.logit <= rq.logit;
                req_if.channel <= rq.channel;
                req_if.grid_col <= rq.grid_col;
                req_if.grid_row <= rq.grid_row;
                req_if.anchor_sel <= rq.anchor_sel;
            end
        end
    end

    // result sink stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_fired)
                out_wait = draw_wait(out_burst);
            if (out_wait > 0)
            begin
                res_if.ready <= 1'b0;
                if (res_if.valid)
                    out_wait--;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // monitor: predict on request, check on result
    always @(posedge clk)
    begin
        logit_req_t rq;
        box_res_t   want;
        item_fired = rst_n && req_if.valid && req_if.ready;
        res_fired = rst_n && res_if.valid && res_if.ready;
        if (item_fired)
        begin
            rq = '{logit: req_if.logit, channel: req_if.channel, grid_col: req_if.grid_col,
                   grid_row: req_if.grid_row, anchor_sel: req_if.anchor_sel};
            decoded_q.push_back(decode_logit(rq));
            reqs_taken++;
        end
        if (res_fired)
        begin
            results_seen++;
            if (res_if.saturated)
                sat_seen++;
            if (decoded_q.size() == 0)
                report_mismatch($sformatf("result %h with nothing expected", res_if.decoded));
            else
            begin
                want = decoded_q.pop_front();
                if (res_if.decoded !== want.decoded)
                    report_mismatch($sformatf("result %0d decoded %h, expected %h",
                                              results_seen, res_if.decoded, want.decoded));
                if (res_if.saturated !== want.saturated)
                    report_mismatch($sformatf("result %0d saturated %b, expected %b",
                                              results_seen, res_if.saturated, want.saturated));
            end
        end
    end

    initial
    begin
        req_if.valid = 1'b0;
        req_if.logit = '0;
        req_if.channel = '0;
        req_if.grid_col = '0;
        req_if.grid_row = '0;
        req_if.anchor_sel = '0;
        res_if.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: default strides, zero anchors
        push_req(16'sh0000, CH_X, 8'd3, 8'd0, 2'd0);
        push_req(16'sh0100, CH_Y, 8'd0, 8'd10, 2'd0);
        push_req(16'sh0200, CH_W, 8'd0, 8'd0, 2'd0);
        push_req(16'shFE00, CH_H, 8'd0, 8'd0, 2'd1);
        drain();

        // widest strides and anchors, with upper write bits set on the strides
        apply_setting(10'h3FF, 10'h3FF, 10'd1023, 10'd1023, 10'd1023,
                      10'd1023, 10'd1023, 10'd1023);
        push_req(16'sh7FFF, CH_X, 8'd255, 8'd0, 2'd0);
        push_req(16'sh8000, CH_X, 8'd0, 8'd255, 2'd1);
        push_req(16'sh0000, CH_Y, 8'd0, 8'd255, 2'd2);
        push_req(16'shFFFF, CH_Y, 8'd255, 8'd0, 2'd3);
        push_req(16'sh7FFF, CH_W, 8'd0, 8'd0, 2'd0);
        push_req(16'sh8000, CH_W, 8'd0, 8'd0, 2'd1);
        push_req(16'sh0000, CH_W, 8'd0, 8'd0, 2'd2);
        push_req(16'sh0300, CH_W, 8'd0, 8'd0, 2'd3);
        push_req(16'sh0800, CH_H, 8'd0, 8'd0, 2'd0);
        push_req(16'shF800, CH_H, 8'd0, 8'd0, 2'd2);
        push_req(16'sh0500, CH_H, 8'd0, 8'd0, 2'd1);
        push_req(16'sh0A00, CH_H, 8'd0, 8'd0, 2'd3);
        push_req(16'sh07FF, CH_CONF, 8'd0, 8'd0, 2'd0);
        push_req(16'sh0800, 8'd5, 8'd255, 8'd255, 2'd2);
        push_req(16'shF7FF, CH_LAST, 8'd0, 8'd0, 2'd0);
        push_req(16'sh0001, CH_CONF, 8'd0, 8'd0, 2'd1);
        push_req(16'sh8000, 8'd200, 8'd0, 8'd0, 2'd3);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == 0)
                apply_setting(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
            else if (ph == 1)
                apply_setting('0, '0, pick_anchor(), pick_anchor(), pick_anchor(),
                              pick_anchor(), pick_anchor(), pick_anchor());
            else
                apply_setting(pick_stride(), pick_stride(), pick_anchor(), pick_anchor(),
                              pick_anchor(), pick_anchor(), pick_anchor(), pick_anchor());
            for (int k = 0; k < PHASE_REQS; k++)
                push_random_req();
            drain();
        end

        $display("%0d requests over %0d register settings, %0d results checked (%0d saturated)",
                 reqs_taken, settings_run, results_seen, sat_seen);
        $display("%0d mismatches", errors);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
